// ===== rtl/core/bph_pkg.sv =====
`default_nettype none
package bph_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int LEVEL_W    = 16;
  localparam int TIMER_W    = 24;
  localparam int TOL_W      = 15;
  localparam int DELTA_W    = 14;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SHOW_HOLD  = 3'd0,
    REG_FLOOR      = 3'd1,
    REG_HOLD_TIME  = 3'd2,
    REG_DECAY      = 3'd3,
    REG_RESET_TOL  = 3'd4,
    REG_SETTLE_TOL = 3'd5,
    REG_BAND_COUNT = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic signed [LEVEL_W-1:0] floor_db;
    logic [TIMER_W-1:0]        hold_time_us;
    logic [15:0]               decay_rate;
    logic [TOL_W-1:0]          reset_tolerance;
    logic [TOL_W-1:0]          settle_tolerance;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    floor_db:         -16'sd30720,
    hold_time_us:     24'd1000000,
    decay_rate:       16'd5120,
    reset_tolerance:  15'd128,
    settle_tolerance: 15'd26
  };
  localparam logic       SHOW_HOLD_RESET  = 1'b1;
  localparam logic [6:0] BAND_COUNT_RESET = 7'd64;

  // delta = (rate * dt + 500000) / 1000000, done as ((x >> 6) / 15625) via reciprocal
  localparam logic [32:0] ROUND_HALF  = 33'd500000;
  localparam int          PRE_SHIFT   = 6;
  localparam logic [27:0] RECIP_MUL   = 28'd140737489;
  localparam int          RECIP_SHIFT = 41;

  localparam logic signed [17:0] LEVEL_MIN_X = -18'sd32768;

  function automatic logic signed [17:0] sext_level(input logic [LEVEL_W-1:0] v);
    return $signed({{2{v[LEVEL_W-1]}}, v});
  endfunction

  function automatic logic level_settled(input logic [LEVEL_W-1:0] level,
                                         input logic [LEVEL_W-1:0] floor_db,
                                         input logic [TOL_W-1:0] tol);
    logic signed [17:0] lim;
    lim = sext_level(floor_db) + $signed({3'b000, tol});
    return sext_level(level) <= lim;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/band_peak_hold_decay_top.sv =====
`default_nettype none
// Per-band peak-hold meter with linear decay.
// Input channel (in_valid/in_ready): one item per band sample or clear command.
// Output channel (out_valid/out_ready): exactly one result item per input item.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): register writes,
// taken only between items.
// Each item is processed in order: read of the band store, decay step through
// two registered multiplies, then write-back, with the result registered at the
// output. A new item is accepted only after the previous write-back, but may be
// accepted while the previous result still waits at the output register; if that
// result is not taken, the write-back of the next item waits for it.
// A clear item (cmd = 1, or show_hold = 0) and a band_count write run a
// pass that invalidates every entry. A floor_db or settle_tolerance write
// runs a pass that recounts the unsettled bands. No item is accepted during
// either pass.
// Reset: registers take their defaults, then an invalidate pass runs over
// every entry before the first item is accepted.
module band_peak_hold_decay_top #(
  parameter int NUM_BANDS  = 64,
  parameter int OWNER_BITS = 4
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [bph_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [bph_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic                                cmd,
  input  logic [5:0]                          band,
  input  logic signed [bph_pkg::LEVEL_W-1:0]  peak_db,
  input  logic                                owner_present,
  input  logic [OWNER_BITS-1:0]               owner_code,
  input  logic [15:0]                         dt_us,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [5:0]                          out_band,
  output logic signed [bph_pkg::LEVEL_W-1:0]  held_db,
  output logic                                held_owner_present,
  output logic [OWNER_BITS-1:0]               held_owner_code,
  output logic                                holding,
  output logic                                all_settled
);
  import bph_pkg::*;

  localparam int AW  = $clog2(NUM_BANDS);
  localparam int UCW = $clog2(NUM_BANDS + 1);
  localparam int CW  = (UCW > 7) ? UCW : 7;
  localparam int EW  = 1 + LEVEL_W + TIMER_W + 1 + OWNER_BITS;
  localparam logic [AW-1:0] LAST_IDX = AW'(NUM_BANDS - 1);

  typedef enum logic [5:0] {
    S_CLEAR     = 6'b000001,
    S_IDLE      = 6'b000010,
    S_MUL       = 6'b000100,
    S_CALC      = 6'b001000,
    S_REFR      = 6'b010000,
    S_REFR_TAIL = 6'b100000
  } state_t;

  state_t         state;
  logic [AW-1:0]  idx;
  logic           pend;
  logic [UCW-1:0] unsettled;
  logic           show_hold;
  cfg_t           cfg;
  logic [6:0]     band_count;

  logic                      kind_clear, kind_skip;
  logic [5:0]                band_r;
  logic signed [LEVEL_W-1:0] peak_r;
  logic                      opres_r;
  logic [OWNER_BITS-1:0]     ocode_r;
  logic [15:0]               dt_r;

  logic           in_fire, cfg_fire, out_free, calc_done;
  logic [CW-1:0]  in_use, band_x, band_r_x;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [EW-1:0]  mem_wdata, mem_rdata;

  logic                      rd_valid, rd_tv, rd_uns;
  logic signed [LEVEL_W-1:0] rd_held;
  logic [TIMER_W-1:0]        rd_timer;
  logic [OWNER_BITS-1:0]     rd_tc;

  logic [DELTA_W-1:0]        delta;
  logic signed [LEVEL_W-1:0] new_held;
  logic [TIMER_W-1:0]        new_timer;
  logic                      new_tv;
  logic [OWNER_BITS-1:0]     new_tc;
  logic                      old_uns, new_uns;
  logic [UCW-1:0]            cnt_calc;

  assign cfg_ready = (state == S_IDLE);
  assign in_ready  = (state == S_IDLE) && !cfg_valid;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign in_fire   = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign calc_done = (state == S_CALC) && out_free;

  assign in_use   = (CW'(band_count) < CW'(NUM_BANDS)) ? CW'(band_count) : CW'(NUM_BANDS);
  assign band_x   = CW'(band);
  assign band_r_x = CW'(band_r);

  assign rd_valid = mem_rdata[EW-1];
  assign rd_held  = mem_rdata[EW-2 -: LEVEL_W];
  assign rd_timer = mem_rdata[EW-2-LEVEL_W -: TIMER_W];
  assign rd_tv    = mem_rdata[OWNER_BITS];
  assign rd_tc    = mem_rdata[OWNER_BITS-1:0];
  assign rd_uns   = rd_valid && !level_settled(rd_held, cfg.floor_db, cfg.settle_tolerance);

  assign mem_re    = in_fire || (state == S_REFR);
  assign mem_raddr = in_fire ? band_x[AW-1:0] : idx;
  assign mem_we    = (state == S_CLEAR) || (calc_done && !kind_clear && !kind_skip);
  assign mem_waddr = (state == S_CLEAR) ? idx : band_r_x[AW-1:0];
  assign mem_wdata = (state == S_CLEAR) ? '0 : {1'b1, new_held, new_timer, new_tv, new_tc};

  assign cnt_calc = unsettled + UCW'(new_uns) - UCW'(old_uns);

  bph_store #(
    .DEPTH (NUM_BANDS),
    .WIDTH (EW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bph_delta u_delta (
    .clk        (clk),
    .load       (in_fire),
    .step       (state == S_MUL),
    .decay_rate (cfg.decay_rate),
    .dt_us      (dt_us),
    .delta      (delta)
  );

  bph_update #(
    .OWNER_BITS (OWNER_BITS)
  ) u_update (
    .cfg           (cfg),
    .peak_db       (peak_r),
    .owner_present (opres_r),
    .owner_code    (ocode_r),
    .dt_us         (dt_r),
    .delta         (delta),
    .ent_valid     (rd_valid),
    .ent_held      (rd_held),
    .ent_timer     (rd_timer),
    .ent_tv        (rd_tv),
    .ent_tc        (rd_tc),
    .new_held      (new_held),
    .new_timer     (new_timer),
    .new_tv        (new_tv),
    .new_tc        (new_tc),
    .old_unsettled (old_uns),
    .new_unsettled (new_uns)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      idx        <= '0;
      pend       <= 1'b0;
      unsettled  <= '0;
      out_valid  <= 1'b0;
      show_hold  <= SHOW_HOLD_RESET;
      cfg        <= CFG_RESET;
      band_count <= BAND_COUNT_RESET;
    end else begin
      pend <= (state == S_REFR);
      if (calc_done) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_CLEAR: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_IDLE: begin
          if (cfg_fire) begin
            case (reg_idx_t'(cfg_index))
              REG_SHOW_HOLD: show_hold <= cfg_data[0];
              REG_FLOOR: begin
                cfg.floor_db <= cfg_data[LEVEL_W-1:0];
                unsettled    <= '0;
                state        <= S_REFR;
              end
              REG_HOLD_TIME: cfg.hold_time_us <= cfg_data[TIMER_W-1:0];
              REG_DECAY: cfg.decay_rate <= cfg_data[15:0];
              REG_RESET_TOL: cfg.reset_tolerance <= cfg_data[TOL_W-1:0];
              REG_SETTLE_TOL: begin
                cfg.settle_tolerance <= cfg_data[TOL_W-1:0];
                unsettled            <= '0;
                state                <= S_REFR;
              end
              REG_BAND_COUNT: begin
                band_count <= cfg_data[6:0];
                unsettled  <= '0;
                state      <= S_CLEAR;
              end
              default: ;
            endcase
          end else if (in_fire) begin
            state <= S_MUL;
          end
        end
        S_MUL: state <= S_CALC;
        S_CALC: begin
          if (out_free) begin
            if (kind_clear) begin
              unsettled <= '0;
              state     <= S_CLEAR;
            end else begin
              if (!kind_skip) begin
                unsettled <= cnt_calc;
              end
              state <= S_IDLE;
            end
          end
        end
        S_REFR: begin
          if (pend && rd_uns) begin
            unsettled <= unsettled + 1'b1;
          end
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_REFR_TAIL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_REFR_TAIL: begin
          if (pend && rd_uns) begin
            unsettled <= unsettled + 1'b1;
          end
          state <= S_IDLE;
        end
        default: state <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      kind_clear <= cmd || !show_hold;
      kind_skip  <= band_x >= in_use;
      band_r     <= band;
      peak_r     <= peak_db;
      opres_r    <= owner_present;
      ocode_r    <= owner_code;
      dt_r       <= dt_us;
    end
    if (calc_done) begin
      if (kind_clear) begin
        out_band           <= '0;
        held_db            <= cfg.floor_db;
        held_owner_present <= 1'b0;
        held_owner_code    <= '0;
        holding            <= 1'b0;
        all_settled        <= 1'b1;
      end else if (kind_skip) begin
        out_band           <= band_r;
        held_db            <= cfg.floor_db;
        held_owner_present <= 1'b0;
        held_owner_code    <= '0;
        holding            <= 1'b0;
        all_settled        <= (unsettled == '0);
      end else begin
        out_band           <= band_r;
        held_db            <= new_held;
        held_owner_present <= new_tv;
        held_owner_code    <= new_tv ? new_tc : '0;
        holding            <= (new_timer != '0);
        all_settled        <= (cnt_calc == '0);
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bph_store.sv =====
`default_nettype none
module bph_store #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 46
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bph_delta.sv =====
`default_nettype none
module bph_delta (
  input  logic                        clk,
  input  logic                        load,
  input  logic                        step,
  input  logic [15:0]                 decay_rate,
  input  logic [15:0]                 dt_us,
  output logic [bph_pkg::DELTA_W-1:0] delta
);
  import bph_pkg::*;

  logic [31:0] prod;
  logic [32:0] rounded;
  logic [26:0] scaled;
  logic [54:0] recip_prod;

  assign rounded = {1'b0, prod} + ROUND_HALF;
  assign scaled  = rounded[32:PRE_SHIFT];
  assign delta   = recip_prod[RECIP_SHIFT+DELTA_W-1:RECIP_SHIFT];

  always_ff @(posedge clk) begin
    if (load) begin
      prod <= 32'(decay_rate) * 32'(dt_us);
    end
    if (step) begin
      recip_prod <= 55'(scaled) * 55'(RECIP_MUL);
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/bph_update.sv =====
`default_nettype none
module bph_update #(
  parameter int OWNER_BITS = 4
) (
  input  bph_pkg::cfg_t                      cfg,
  input  logic signed [bph_pkg::LEVEL_W-1:0] peak_db,
  input  logic                               owner_present,
  input  logic [OWNER_BITS-1:0]              owner_code,
  input  logic [15:0]                        dt_us,
  input  logic [bph_pkg::DELTA_W-1:0]        delta,
  input  logic                               ent_valid,
  input  logic signed [bph_pkg::LEVEL_W-1:0] ent_held,
  input  logic [bph_pkg::TIMER_W-1:0]        ent_timer,
  input  logic                               ent_tv,
  input  logic [OWNER_BITS-1:0]              ent_tc,
  output logic signed [bph_pkg::LEVEL_W-1:0] new_held,
  output logic [bph_pkg::TIMER_W-1:0]        new_timer,
  output logic                               new_tv,
  output logic [OWNER_BITS-1:0]              new_tc,
  output logic                               old_unsettled,
  output logic                               new_unsettled
);
  import bph_pkg::*;

  logic signed [LEVEL_W-1:0] held0;
  logic [TIMER_W-1:0]        timer0;
  logic                      tv0;
  logic [OWNER_BITS-1:0]     tc0;
  logic signed [17:0]        floor_x, peak_x, held0_x, tol_x, nl_x;
  logic signed [LEVEL_W-1:0] decayed;
  logic                      contrib;

  always_comb begin
    held0   = ent_valid ? ent_held : cfg.floor_db;
    timer0  = ent_valid ? ent_timer : '0;
    tv0     = ent_valid & ent_tv;
    tc0     = ent_valid ? ent_tc : '0;
    floor_x = sext_level(cfg.floor_db);
    peak_x  = sext_level(peak_db);
    held0_x = sext_level(held0);
    tol_x   = $signed({3'b000, cfg.reset_tolerance});
    nl_x    = held0_x - $signed({4'b0000, delta});
    decayed = (nl_x < LEVEL_MIN_X) ? 16'sh8000 : nl_x[LEVEL_W-1:0];
    contrib = peak_x > floor_x;

    new_held  = held0;
    new_timer = timer0;
    new_tv    = tv0;
    new_tc    = tc0;
    if (contrib && peak_x >= held0_x) begin
      new_held  = peak_db;
      new_timer = cfg.hold_time_us;
      new_tv    = owner_present;
      new_tc    = owner_present ? owner_code : '0;
    end else if (contrib && peak_x >= held0_x - tol_x) begin
      new_timer = cfg.hold_time_us;
    end else if (timer0 != '0) begin
      new_timer = (timer0 > TIMER_W'(dt_us)) ? timer0 - TIMER_W'(dt_us) : '0;
    end else begin
      new_held = decayed;
      // recapture
      if (contrib && sext_level(decayed) <= peak_x + tol_x) begin
        new_held  = peak_db;
        new_timer = cfg.hold_time_us;
        if (owner_present) begin
          new_tv = 1'b1;
          new_tc = owner_code;
        end
      end
      // snap to floor
      if (level_settled(new_held, cfg.floor_db, cfg.settle_tolerance) && !owner_present) begin
        new_held  = cfg.floor_db;
        new_timer = '0;
        new_tv    = 1'b0;
        new_tc    = '0;
      end
    end

    new_unsettled = !level_settled(new_held, cfg.floor_db, cfg.settle_tolerance);
    old_unsettled = ent_valid && !level_settled(ent_held, cfg.floor_db, cfg.settle_tolerance);
  end

endmodule
`default_nettype wire
